>>> rtl/jic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jet identification classifier package
// Shared widths, codes and structures of the jet quality classifier.
// ----------------------------------------------------------------------------
package jic_pkg;

	// Field widths.
	localparam int CLASS_W    = 3;
	localparam int ENERGY_W   = 16;
	localparam int PT_W       = 16;
	localparam int SCALE_W    = 10;
	localparam int ETA_W      = 9;
	localparam int PCT_W      = 7;
	localparam int COUNT_W    = 9;
	localparam int SUM_W      = 24;
	localparam int GRADE_W    = 3;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Fractions are compared as part * 100 against pct * total.
	localparam int PCT_SCALE = 100;
	localparam int FRAC_W    = SUM_W + PCT_W;

	// Corrected pt compares as pt * scale against threshold * 256.
	localparam int SCALE_SHIFT = 8;
	localparam int PTPROD_W    = PT_W + SCALE_W;

	// Configuration register reset values.
	localparam logic [PT_W-1:0]  PT_THRESHOLD_RST = 16'd160;
	localparam logic [ETA_W-1:0] ETA_BOUNDARY_RST = 9'd240;
	localparam logic [PCT_W-1:0] MEDIUM_PCT_RST   = 7'd95;
	localparam logic [PCT_W-1:0] TIGHT_PCT_RST    = 7'd90;

	// Register indexes on the configuration port.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PT_THRESHOLD = 2'd0,
		REG_ETA_BOUNDARY = 2'd1,
		REG_MEDIUM_PCT   = 2'd2,
		REG_TIGHT_PCT    = 2'd3
	} jic_reg_idx_t;

	// Particle-flow classes.
	typedef enum logic [CLASS_W-1:0] {
		CLS_CHARGED    = 3'd0,
		CLS_PHOTON     = 3'd1,
		CLS_NEUTRAL    = 3'd2,
		CLS_ELECTRON   = 3'd3,
		CLS_FWD_HADRON = 3'd4,
		CLS_FWD_EGAMMA = 3'd5
	} jic_class_t;

	// Jet quality grades.
	typedef enum logic [GRADE_W-1:0] {
		GRADE_FAIL   = 3'd0,
		GRADE_LOOSE  = 3'd1,
		GRADE_MEDIUM = 3'd2,
		GRADE_TIGHT  = 3'd3,
		GRADE_BYPASS = 3'd4
	} jic_grade_t;

	// One constituent word on the input channel.
	typedef struct packed {
		logic                constituent_valid;
		logic [CLASS_W-1:0]  particle_class;
		logic [ENERGY_W-1:0] constituent_energy;
		logic [PT_W-1:0]     jet_pt;
		logic [SCALE_W-1:0]  jet_scale;
		logic [ETA_W-1:0]    jet_abs_eta;
		logic                last_item;
	} jic_item_t;

	// One result word on the output channel.
	typedef struct packed {
		logic [GRADE_W-1:0] jet_grade;
		logic [COUNT_W-1:0] constituent_total;
	} jic_result_t;

	// Configuration register file.
	typedef struct packed {
		logic [PT_W-1:0]  pt_threshold;
		logic [ETA_W-1:0] eta_boundary;
		logic [PCT_W-1:0] medium_fraction_pct;
		logic [PCT_W-1:0] tight_fraction_pct;
	} jic_cfg_t;

	// Per-jet counts and energy sums.
	typedef struct packed {
		logic [COUNT_W-1:0] count_all;
		logic [COUNT_W-1:0] count_charged;
		logic [COUNT_W-1:0] count_photon;
		logic [COUNT_W-1:0] count_neutral;
		logic [SUM_W-1:0]   sum_total;
		logic [SUM_W-1:0]   sum_charged;
		logic [SUM_W-1:0]   sum_photon;
		logic [SUM_W-1:0]   sum_neutral;
		logic [SUM_W-1:0]   sum_electron;
	} jic_jet_t;

endpackage
`default_nettype wire

>>> rtl/jic_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jet identification stream interface
// Valid/ready channel carrying one word of a given type per handshake.
// ----------------------------------------------------------------------------
interface jic_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

>>> rtl/jic_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jet identification accumulator
// Saturating per-class constituent counts and energy sums of the open jet.
// ----------------------------------------------------------------------------
module jic_accum #(
	parameter int MAX_CONSTITUENTS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire jic_pkg::jic_item_t item,
	output jic_pkg::jic_jet_t      jet_total
);
	import jic_pkg::*;

	localparam int CAP_INT = (MAX_CONSTITUENTS > 511) ? 511 : MAX_CONSTITUENTS;
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_INT);
	localparam logic [SUM_W-1:0]   SUM_CAP   = '1;

	jic_jet_t acc_q;
	jic_jet_t acc_next;

	function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
		return (c < COUNT_CAP) ? c + 1'b1 : COUNT_CAP;
	endfunction

	function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] s,
			input logic [ENERGY_W-1:0] e);
		logic [SUM_W:0] r;
		r = {1'b0, s} + {{(SUM_W + 1 - ENERGY_W){1'b0}}, e};
		return r[SUM_W] ? SUM_CAP : r[SUM_W-1:0];
	endfunction

	// Fold the current constituent into the running totals.
	always_comb begin
		acc_next = acc_q;
		if (item.constituent_valid) begin
			acc_next.count_all = bump(acc_q.count_all);
			acc_next.sum_total = add_sat(acc_q.sum_total, item.constituent_energy);
			case (item.particle_class)
				CLS_CHARGED: begin
					acc_next.count_charged = bump(acc_q.count_charged);
					acc_next.sum_charged = add_sat(acc_q.sum_charged, item.constituent_energy);
				end
				CLS_PHOTON, CLS_FWD_EGAMMA: begin
					acc_next.count_photon = bump(acc_q.count_photon);
					acc_next.sum_photon = add_sat(acc_q.sum_photon, item.constituent_energy);
				end
				CLS_NEUTRAL, CLS_FWD_HADRON: begin
					acc_next.count_neutral = bump(acc_q.count_neutral);
					acc_next.sum_neutral = add_sat(acc_q.sum_neutral, item.constituent_energy);
				end
				CLS_ELECTRON: begin
					acc_next.sum_electron = add_sat(acc_q.sum_electron,
						item.constituent_energy);
				end
				default: begin
				end
			endcase
		end
	end

	assign jet_total = acc_next;

	// Totals restart from zero after the last word of a jet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (step) begin
			acc_q <= item.last_item ? '0 : acc_next;
		end
	end

	// A class count never runs ahead of the jet's total count.
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.count_charged <= acc_q.count_all && acc_q.count_photon <= acc_q.count_all &&
		acc_q.count_neutral <= acc_q.count_all)
		else $error("class count exceeds total count");

	// A class energy sum never exceeds the total sum, saturated or not.
	a_sum_order: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.sum_charged <= acc_q.sum_total && acc_q.sum_photon <= acc_q.sum_total &&
		acc_q.sum_neutral <= acc_q.sum_total && acc_q.sum_electron <= acc_q.sum_total)
		else $error("class energy sum exceeds total sum");

	// Closing a jet leaves the accumulators clear.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_item |=> acc_q == '0)
		else $error("accumulators not cleared after last word");

endmodule
`default_nettype wire

>>> rtl/jic_grade.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jet identification grader
// Grades one closed jet from its totals, kinematics and the configuration.
// ----------------------------------------------------------------------------
module jic_grade (
	input  wire jic_pkg::jic_jet_t          jet,
	input  wire logic [jic_pkg::PT_W-1:0]    jet_pt,
	input  wire logic [jic_pkg::SCALE_W-1:0] jet_scale,
	input  wire logic [jic_pkg::ETA_W-1:0]   jet_abs_eta,
	input  wire jic_pkg::jic_cfg_t          cfg,
	output jic_pkg::jic_grade_t             grade
);
	import jic_pkg::*;

	logic [PTPROD_W-1:0] pt_prod;
	logic [PTPROD_W-1:0] pt_limit;
	logic [FRAC_W-1:0]   neutral_x100;
	logic [FRAC_W-1:0]   photon_x100;
	logic [FRAC_W-1:0]   medium_lim;
	logic [FRAC_W-1:0]   tight_lim;
	logic                bypass;
	logic                base;
	logic                central;
	logic                loose;
	logic                medium_ok;
	logic                tight;

	// Corrected pt against the threshold, both sides scaled by 256.
	assign pt_prod  = PTPROD_W'(jet_pt) * PTPROD_W'(jet_scale);
	assign pt_limit = PTPROD_W'({cfg.pt_threshold, {SCALE_SHIFT{1'b0}}});
	assign bypass   = pt_prod < pt_limit;

	// Cross-multiplied fraction terms.
	assign neutral_x100 = FRAC_W'(jet.sum_neutral) * FRAC_W'(PCT_SCALE);
	assign photon_x100  = FRAC_W'(jet.sum_photon) * FRAC_W'(PCT_SCALE);
	assign medium_lim   = FRAC_W'(cfg.medium_fraction_pct) * FRAC_W'(jet.sum_total);
	assign tight_lim    = FRAC_W'(cfg.tight_fraction_pct) * FRAC_W'(jet.sum_total);

	// Loose, medium and tight rules; a jet on the boundary is forward.
	always_comb begin
		base = (jet.count_all > COUNT_W'(1)) && (jet.sum_neutral < jet.sum_total) &&
			(jet.sum_photon < jet.sum_total);
		central = jet_abs_eta < cfg.eta_boundary;
		if (central) begin
			loose = base && (jet.sum_charged != '0) && (jet.count_charged != '0) &&
				(jet.sum_electron < jet.sum_total);
			medium_ok = loose;
			tight = loose;
		end else begin
			loose = base;
			medium_ok = base && (neutral_x100 < medium_lim) && (photon_x100 < medium_lim);
			tight = base && (neutral_x100 < tight_lim) && (photon_x100 < tight_lim);
		end
	end

	// Combine the rules; bypass wins, and a jet that is not loose or has disordered outcomes fails.
	always_comb begin
		if (bypass) begin
			grade = GRADE_BYPASS;
		end else if (loose && !medium_ok && !tight) begin
			grade = GRADE_LOOSE;
		end else if (loose && medium_ok && !tight) begin
			grade = GRADE_MEDIUM;
		end else if (loose && medium_ok && tight) begin
			grade = GRADE_TIGHT;
		end else begin
			grade = GRADE_FAIL;
		end
	end

endmodule
`default_nettype wire

>>> rtl/jet_identification_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jet identification classifier
// Streams particle-flow constituents of a jet and grades the jet on its last
// word as fail, loose, medium, tight or bypass.
// ----------------------------------------------------------------------------
// The block takes one constituent word every clock cycle, unless a closing
// word is held by back-pressure, with no gaps needed between jets. Each word
// is registered, then folded into saturating class counts and energy sums; on
// the word marked last the closed totals move to a grading register, and the
// grade, reached through a few narrow multipliers and compares, lands in the
// output register, from which the result word is offered. Back-pressure on
// the result channel holds a word that closes a jet once the grading and
// output registers are both full, and new words wait behind it. The user
// must write the registers on the plain write port only while no jet is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module jet_identification_classifier #(
	parameter int MAX_CONSTITUENTS = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           write_enable,
	input  wire logic [jic_pkg::REG_IDX_W-1:0]  register_index,
	input  wire logic [jic_pkg::CFG_DATA_W-1:0] write_data,
	jic_stream_if.sink                          items,
	jic_stream_if.source                        grades
);
	import jic_pkg::*;

	localparam int CAP_INT = (MAX_CONSTITUENTS > 511) ? 511 : MAX_CONSTITUENTS;
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_INT);

	jic_cfg_t         cfg_q;
	logic             valid_s1;
	jic_item_t        item_s1;
	logic             valid_s2;
	jic_jet_t         jet_s2;
	logic [PT_W-1:0]  pt_s2;
	logic [SCALE_W-1:0] scale_s2;
	logic [ETA_W-1:0] eta_s2;
	logic             out_valid_q;
	jic_result_t      out_word_q;
	jic_jet_t         jet_total;
	jic_grade_t       grade;
	logic             out_free;
	logic             s2_free;
	logic             adv_s1;
	logic             step;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pt_threshold        <= PT_THRESHOLD_RST;
			cfg_q.eta_boundary        <= ETA_BOUNDARY_RST;
			cfg_q.medium_fraction_pct <= MEDIUM_PCT_RST;
			cfg_q.tight_fraction_pct  <= TIGHT_PCT_RST;
		end else if (write_enable) begin
			case (jic_reg_idx_t'(register_index))
				REG_PT_THRESHOLD: cfg_q.pt_threshold <= write_data[PT_W-1:0];
				REG_ETA_BOUNDARY: cfg_q.eta_boundary <= write_data[ETA_W-1:0];
				REG_MEDIUM_PCT:   cfg_q.medium_fraction_pct <= write_data[PCT_W-1:0];
				REG_TIGHT_PCT:    cfg_q.tight_fraction_pct <= write_data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Flow control: only a closing word needs room downstream.
	assign out_free    = !out_valid_q || grades.ready;
	assign s2_free     = !valid_s2 || out_free;
	assign adv_s1      = !item_s1.last_item || s2_free;
	assign step        = valid_s1 && adv_s1;
	assign items.ready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= items.word;
		end
	end

	jic_accum #(
		.MAX_CONSTITUENTS(MAX_CONSTITUENTS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.jet_total (jet_total)
	);

	// Grading register holds the totals of a closed jet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= step && item_s1.last_item;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && step && item_s1.last_item) begin
			jet_s2   <= jet_total;
			pt_s2    <= item_s1.jet_pt;
			scale_s2 <= item_s1.jet_scale;
			eta_s2   <= item_s1.jet_abs_eta;
		end
	end

	jic_grade u_grade (
		.jet         (jet_s2),
		.jet_pt      (pt_s2),
		.jet_scale   (scale_s2),
		.jet_abs_eta (eta_s2),
		.cfg         (cfg_q),
		.grade       (grade)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			out_word_q.jet_grade         <= grade;
			out_word_q.constituent_total <= jet_s2.count_all;
		end
	end

	assign grades.valid = out_valid_q;
	assign grades.word  = out_word_q;

	// A graded jet always reaches the output register.
	a_grade_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_free |=> out_valid_q)
		else $error("graded jet lost before output register");

	// The offered result stays within the grade codes and the count cap.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_word_q.jet_grade <= GRADE_BYPASS &&
		out_word_q.constituent_total <= COUNT_CAP)
		else $error("result word out of range");

	// Input stalls only behind a waiting closing word.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> valid_s1 && item_s1.last_item && valid_s2 && out_valid_q)
		else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire
